// ----- hdl/imadec_pkg.sv -----
// ============================================================================
// imadec_pkg: shared types, constants and functions of the ADPCM voice decoder
// Holds the step table, the index adjustment and the one-nibble decode step.
// ============================================================================
package imadec_pkg;

    localparam int STEP_TABLE_SIZE     = 89;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [6:0]         MAX_INDEX    = 7'(STEP_TABLE_SIZE - 1);
    localparam logic [18:0]        HEADER_BYTES = 19'd4;
    localparam logic signed [17:0] SAT_POS      = 18'sd32767;
    localparam logic signed [17:0] SAT_NEG      = -18'sd32767;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    typedef enum logic [1:0] {
        OP_HEADER,
        OP_DATA,
        OP_RESTART
    } op_t;

    // payload: header -> {step index [22:16], predictor [15:0]}; byte in [7:0]
    typedef struct packed {
        op_t         op;
        logic        save_loop;
        logic [22:0] payload;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] pred;
        logic [6:0]         idx;
    } dec_state_t;

    function automatic logic [15:0] step_value(input logic [6:0] idx);
        logic [15:0] v;
        unique case (idx)
            7'd0:  v = 16'h0007;  7'd1:  v = 16'h0008;  7'd2:  v = 16'h0009;
            7'd3:  v = 16'h000A;  7'd4:  v = 16'h000B;  7'd5:  v = 16'h000C;
            7'd6:  v = 16'h000D;  7'd7:  v = 16'h000E;  7'd8:  v = 16'h0010;
            7'd9:  v = 16'h0011;  7'd10: v = 16'h0013;  7'd11: v = 16'h0015;
            7'd12: v = 16'h0017;  7'd13: v = 16'h0019;  7'd14: v = 16'h001C;
            7'd15: v = 16'h001F;  7'd16: v = 16'h0022;  7'd17: v = 16'h0025;
            7'd18: v = 16'h0029;  7'd19: v = 16'h002D;  7'd20: v = 16'h0032;
            7'd21: v = 16'h0037;  7'd22: v = 16'h003C;  7'd23: v = 16'h0042;
            7'd24: v = 16'h0049;  7'd25: v = 16'h0050;  7'd26: v = 16'h0058;
            7'd27: v = 16'h0061;  7'd28: v = 16'h006B;  7'd29: v = 16'h0076;
            7'd30: v = 16'h0082;  7'd31: v = 16'h008F;  7'd32: v = 16'h009D;
            7'd33: v = 16'h00AD;  7'd34: v = 16'h00BE;  7'd35: v = 16'h00D1;
            7'd36: v = 16'h00E6;  7'd37: v = 16'h00FD;  7'd38: v = 16'h0117;
            7'd39: v = 16'h0133;  7'd40: v = 16'h0151;  7'd41: v = 16'h0173;
            7'd42: v = 16'h0198;  7'd43: v = 16'h01C1;  7'd44: v = 16'h01EE;
            7'd45: v = 16'h0220;  7'd46: v = 16'h0256;  7'd47: v = 16'h0292;
            7'd48: v = 16'h02D4;  7'd49: v = 16'h031C;  7'd50: v = 16'h036C;
            7'd51: v = 16'h03C3;  7'd52: v = 16'h0424;  7'd53: v = 16'h048E;
            7'd54: v = 16'h0502;  7'd55: v = 16'h0583;  7'd56: v = 16'h0610;
            7'd57: v = 16'h06AB;  7'd58: v = 16'h0756;  7'd59: v = 16'h0812;
            7'd60: v = 16'h08E0;  7'd61: v = 16'h09C3;  7'd62: v = 16'h0ABD;
            7'd63: v = 16'h0BD0;  7'd64: v = 16'h0CFF;  7'd65: v = 16'h0E4C;
            7'd66: v = 16'h0FBA;  7'd67: v = 16'h114C;  7'd68: v = 16'h1307;
            7'd69: v = 16'h14EE;  7'd70: v = 16'h1706;  7'd71: v = 16'h1954;
            7'd72: v = 16'h1BDC;  7'd73: v = 16'h1EA5;  7'd74: v = 16'h21B6;
            7'd75: v = 16'h2515;  7'd76: v = 16'h28CA;  7'd77: v = 16'h2CDF;
            7'd78: v = 16'h315B;  7'd79: v = 16'h364B;  7'd80: v = 16'h3BB9;
            7'd81: v = 16'h41B2;  7'd82: v = 16'h4844;  7'd83: v = 16'h4F7E;
            7'd84: v = 16'h5771;  7'd85: v = 16'h602F;  7'd86: v = 16'h69CE;
            7'd87: v = 16'h7462;  7'd88: v = 16'h7FFF;
            default: v = 16'h7FFF;
        endcase
        return v;
    endfunction

    function automatic logic signed [8:0] index_adjust(input logic [2:0] code);
        logic signed [8:0] a;
        unique case (code)
            3'd4:    a = 9'sd2;
            3'd5:    a = 9'sd4;
            3'd6:    a = 9'sd6;
            3'd7:    a = 9'sd8;
            default: a = -9'sd1;
        endcase
        return a;
    endfunction

    function automatic dec_state_t decode_nibble(
        input logic signed [15:0] pred,
        input logic [6:0]         idx_in,
        input logic [3:0]         nib
    );
        logic [6:0]         idx;
        logic [15:0]        val;
        logic [16:0]        diff;
        logic signed [17:0] acc;
        logic signed [8:0]  ni;
        dec_state_t         res;
        idx  = (idx_in > MAX_INDEX) ? MAX_INDEX : idx_in;
        val  = step_value(idx);
        diff = {4'b0, val[15:3]};
        if (nib[0])
            diff = diff + {3'b0, val[15:2]};
        if (nib[1])
            diff = diff + {2'b0, val[15:1]};
        if (nib[2])
            diff = diff + {1'b0, val};
        if (nib[3])
        begin
            acc = {{2{pred[15]}}, pred} - $signed({1'b0, diff});
            if (acc < SAT_NEG)
                acc = SAT_NEG;
        end
        else
        begin
            acc = {{2{pred[15]}}, pred} + $signed({1'b0, diff});
            if (acc > SAT_POS)
                acc = SAT_POS;
        end
        ni = $signed({2'b0, idx}) + index_adjust(nib[2:0]);
        if (ni < 9'sd0)
            ni = 9'sd0;
        else if (ni > $signed({2'b0, MAX_INDEX}))
            ni = $signed({2'b0, MAX_INDEX});
        res.pred = acc[15:0];
        res.idx  = ni[6:0];
        return res;
    endfunction

endpackage

// ----- hdl/ima_adpcm_voice_decoder.sv -----
// ============================================================================
// ima_adpcm_voice_decoder: 4-bit IMA ADPCM decoder for one voice
// Front end, command queue and decode stage with a registered output.
// ============================================================================
// A header transfer loads the predictor and step index and yields no sample;
// a data byte yields two samples, low nibble first, the second with tlast; a
// loop restart yields the saved predictor and then its decoded high nibble.
// The decode stage runs one nibble per cycle while the output register is
// free, through a single step-table lookup, adder and saturation; a data
// byte or restart occupies it for a low and a high half and a header only
// loads its state, while the queue takes further items. The output register
// is reloaded in the cycle its sample is taken, so a stalled sink holds byte
// and restart steps while the queue keeps accepting until it is full. An
// item's first sample goes from the queue entry to the output register.
// Write loop_start_byte only while the decoder is idle.
module ima_adpcm_voice_decoder
#(
    parameter int QUEUE_DEPTH = imadec_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // data
    input  logic [1:0]           s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic signed [15:0]   m_tdata,   // sample
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [17:0]          cfg_data   // loop_start_byte
);

    logic             push_valid;
    logic             push_ready;
    imadec_pkg::cmd_t push_cmd;
    logic             q_valid;
    logic             q_ready;
    imadec_pkg::cmd_t q_cmd;

    imadec_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    imadec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    imadec_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/imadec_front.sv -----
// ============================================================================
// imadec_front: input acceptance and classification
// Turns input transfers into decode commands, drops stray kinds, tracks the
// byte offset and marks the byte whose low nibble sets the loop point.
// ============================================================================
module imadec_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // data
    input  logic [1:0]           s_tuser,   // kind
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [17:0]          cfg_data,  // loop_start_byte
    output logic                 push_valid,
    input  logic                 push_ready,
    output imadec_pkg::cmd_t     push_cmd
);

    logic [17:0] loop_start_reg;
    logic [18:0] offset_reg;
    logic [18:0] offset_next;
    logic [6:0]  hdr_idx;
    logic        accept;
    logic        known;

    assign cfg_ready = 1'b1;
    assign s_tready  = push_ready;
    assign accept    = s_tvalid && s_tready;

    assign hdr_idx = (s_tdata[22:16] > imadec_pkg::MAX_INDEX) ?
                     imadec_pkg::MAX_INDEX : s_tdata[22:16];

    always_comb
    begin
        known                = 1'b1;
        offset_next          = offset_reg;
        push_cmd.op          = imadec_pkg::OP_DATA;
        push_cmd.save_loop   = 1'b0;
        push_cmd.payload     = {hdr_idx, s_tdata[15:0]};
        unique case (s_tuser)
            imadec_pkg::KIND_HEADER:
            begin
                push_cmd.op = imadec_pkg::OP_HEADER;
                offset_next = imadec_pkg::HEADER_BYTES;
            end
            imadec_pkg::KIND_DATA:
            begin
                push_cmd.op        = imadec_pkg::OP_DATA;
                push_cmd.save_loop = (offset_reg == {1'b0, loop_start_reg});
                offset_next        = offset_reg + 19'd1;
            end
            imadec_pkg::KIND_RESTART:
            begin
                push_cmd.op = imadec_pkg::OP_RESTART;
                offset_next = {1'b0, loop_start_reg} + 19'd1;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    assign push_valid = s_tvalid && known;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_start_reg <= '0;
            offset_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                loop_start_reg <= cfg_data;
            if (accept)
                offset_reg <= offset_next;
        end
    end

endmodule

// ----- hdl/imadec_queue.sv -----
// ============================================================================
// imadec_queue: short command queue
// Decouples the front from the decode stage so that each can stall alone.
// ============================================================================
module imadec_queue
#(
    parameter int DEPTH = imadec_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  imadec_pkg::cmd_t     push_cmd,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output imadec_pkg::cmd_t     pop_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    imadec_pkg::cmd_t entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hdl/imadec_back.sv -----
// ============================================================================
// imadec_back: decode stage and output register
// Runs one nibble step per cycle unless its output waits, saves and restores
// the loop point and holds each sample in its output register until taken.
// ============================================================================
module imadec_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  imadec_pkg::cmd_t     q_cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic signed [15:0]   m_tdata,   // sample
    output logic                 m_tlast
);

    logic signed [15:0]     pred_reg;
    logic signed [15:0]     pred_next;
    logic [6:0]             idx_reg;
    logic [6:0]             idx_next;
    logic signed [15:0]     loop_pred_reg;
    logic signed [15:0]     loop_pred_next;
    logic [6:0]             loop_idx_reg;
    logic [6:0]             loop_idx_next;
    logic                   phase_reg;
    logic                   phase_next;
    logic                   out_valid_reg;
    logic signed [15:0]     out_sample_reg;
    logic signed [15:0]     out_sample_next;
    logic                   out_last_reg;
    logic                   out_last_next;
    logic                   out_load;
    logic                   out_free;
    logic                   step;
    logic [3:0]             nib;
    imadec_pkg::dec_state_t dec;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = q_valid && ((q_cmd.op == imadec_pkg::OP_HEADER) || out_free);
    assign nib      = phase_reg ? q_cmd.payload[7:4] : q_cmd.payload[3:0];
    assign dec      = imadec_pkg::decode_nibble(pred_reg, idx_reg, nib);

    always_comb
    begin
        pred_next       = pred_reg;
        idx_next        = idx_reg;
        loop_pred_next  = loop_pred_reg;
        loop_idx_next   = loop_idx_reg;
        phase_next      = phase_reg;
        out_load        = 1'b0;
        out_sample_next = dec.pred;
        out_last_next   = phase_reg;
        q_ready         = 1'b0;
        if (step)
        begin
            unique case (q_cmd.op)
                imadec_pkg::OP_HEADER:
                begin
                    pred_next      = q_cmd.payload[15:0];
                    idx_next       = q_cmd.payload[22:16];
                    loop_pred_next = q_cmd.payload[15:0];
                    loop_idx_next  = q_cmd.payload[22:16];
                    q_ready        = 1'b1;
                end
                imadec_pkg::OP_DATA:
                begin
                    pred_next  = dec.pred;
                    idx_next   = dec.idx;
                    out_load   = 1'b1;
                    phase_next = !phase_reg;
                    q_ready    = phase_reg;
                    if (!phase_reg && q_cmd.save_loop)
                    begin
                        loop_pred_next = dec.pred;
                        loop_idx_next  = dec.idx;
                    end
                end
                imadec_pkg::OP_RESTART:
                begin
                    out_load   = 1'b1;
                    phase_next = !phase_reg;
                    q_ready    = phase_reg;
                    if (!phase_reg)
                    begin
                        pred_next       = loop_pred_reg;
                        idx_next        = loop_idx_reg;
                        out_sample_next = loop_pred_reg;
                    end
                    else
                    begin
                        pred_next = dec.pred;
                        idx_next  = dec.idx;
                    end
                end
                default:
                begin
                    q_ready = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg      <= '0;
            idx_reg       <= '0;
            loop_pred_reg <= '0;
            loop_idx_reg  <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pred_reg      <= pred_next;
            idx_reg       <= idx_next;
            loop_pred_reg <= loop_pred_next;
            loop_idx_reg  <= loop_idx_next;
            phase_reg     <= phase_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sample_reg <= out_sample_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tlast  = out_last_reg;

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg <= imadec_pkg::MAX_INDEX) && (loop_idx_reg <= imadec_pkg::MAX_INDEX))
        else $error("step index beyond table");

    a_second_half_holds_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> q_valid && ((q_cmd.op == imadec_pkg::OP_DATA) ||
                                  (q_cmd.op == imadec_pkg::OP_RESTART)))
        else $error("second half without its byte command");

    a_first_half_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !phase_reg && ((q_cmd.op == imadec_pkg::OP_DATA) ||
                                (q_cmd.op == imadec_pkg::OP_RESTART))) |=> phase_reg)
        else $error("first half did not advance to second half");

endmodule

// ----- dv/tb_ima_adpcm_voice_decoder.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_ima_adpcm_voice_decoder: self-checking bench for the ADPCM voice decoder
// Drives headers, data bytes, loop restarts and stray kinds through the input
// stream and predicts every decoded sample from a local decoder model. Each
// output transfer is checked in order against the predicted queue; later
// random sounds add random source gaps, sink stalls or both. Directed cases
// come first, then random sounds over several loop-start settings.
// ============================================================================
module tb_ima_adpcm_voice_decoder;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         SETTLE_CYC   = 8;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         MAX_REPORTS  = 10;
    localparam int         TOP_INDEX    = 88;
    localparam logic [17:0] LOOP_MAX    = 18'h3FFFF;

    // step sizes, entry 0 in the low bits
    localparam logic [89*16-1:0] STEP_SIZES = {16'h7FFF,
        16'h7462, 16'h69CE, 16'h602F, 16'h5771, 16'h4F7E, 16'h4844, 16'h41B2, 16'h3BB9,
        16'h364B, 16'h315B, 16'h2CDF, 16'h28CA, 16'h2515, 16'h21B6, 16'h1EA5, 16'h1BDC,
        16'h1954, 16'h1706, 16'h14EE, 16'h1307, 16'h114C, 16'h0FBA, 16'h0E4C, 16'h0CFF,
        16'h0BD0, 16'h0ABD, 16'h09C3, 16'h08E0, 16'h0812, 16'h0756, 16'h06AB, 16'h0610,
        16'h0583, 16'h0502, 16'h048E, 16'h0424, 16'h03C3, 16'h036C, 16'h031C, 16'h02D4,
        16'h0292, 16'h0256, 16'h0220, 16'h01EE, 16'h01C1, 16'h0198, 16'h0173, 16'h0151,
        16'h0133, 16'h0117, 16'h00FD, 16'h00E6, 16'h00D1, 16'h00BE, 16'h00AD, 16'h009D,
        16'h008F, 16'h0082, 16'h0076, 16'h006B, 16'h0061, 16'h0058, 16'h0050, 16'h0049,
        16'h0042, 16'h003C, 16'h0037, 16'h0032, 16'h002D, 16'h0029, 16'h0025, 16'h0022,
        16'h001F, 16'h001C, 16'h0019, 16'h0017, 16'h0015, 16'h0013, 16'h0011, 16'h0010,
        16'h000E, 16'h000D, 16'h000C, 16'h000B, 16'h000A, 16'h0009, 16'h0008, 16'h0007};

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } pcm_out_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;   // data
    logic [1:0]          s_tuser;   // kind
    logic                m_tvalid;
    logic                m_tready;
    logic signed [15:0]  m_tdata;   // sample
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [17:0]         cfg_data;  // loop_start_byte

    // decoder model state
    logic signed [15:0]  voice_pred;
    logic [6:0]          voice_idx;
    logic signed [15:0]  saved_pred;
    logic [6:0]          saved_idx;
    logic [18:0]         byte_pos;
    logic [17:0]         loop_byte;

    pcm_out_t            pcm_expected[$];
    pcm_out_t            want_pcm;
    int                  mismatch_count;
    int                  src_idle_pct;
    int                  sink_stall_pct;
    int                  quiet_cycles;

    ima_adpcm_voice_decoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void adpcm_step(input logic [3:0] nib);
        int step;
        int diff;
        int acc;
        int nidx;
        step = int'(STEP_SIZES[voice_idx*16 +: 16]);
        diff = step >> 3;
        if (nib[0])
            diff += step >> 2;
        if (nib[1])
            diff += step >> 1;
        if (nib[2])
            diff += step;
        if (nib[3])
        begin
            acc = int'(voice_pred) - diff;
            if (acc < -32767)
                acc = -32767;
        end
        else
        begin
            acc = int'(voice_pred) + diff;
            if (acc > 32767)
                acc = 32767;
        end
        nidx = nib[2] ? int'(voice_idx) + 2 * (int'(nib[1:0]) + 1) : int'(voice_idx) - 1;
        if (nidx < 0)
            nidx = 0;
        else if (nidx > TOP_INDEX)
            nidx = TOP_INDEX;
        voice_pred = acc[15:0];
        voice_idx  = nidx[6:0];
    endfunction

    function automatic void push_pcm(input logic last);
        pcm_out_t r;
        r.sample = voice_pred;
        r.last   = last;
        pcm_expected.push_back(r);
    endfunction

    function automatic void predict_pcm(input logic [1:0] kind, input logic [31:0] data);
        case (kind)
            imadec_pkg::KIND_HEADER:
            begin
                voice_pred = data[15:0];
                voice_idx  = (data[22:16] > 7'(TOP_INDEX)) ? 7'(TOP_INDEX) : data[22:16];
                saved_pred = voice_pred;
                saved_idx  = voice_idx;
                byte_pos   = imadec_pkg::HEADER_BYTES;
            end
            imadec_pkg::KIND_DATA:
            begin
                adpcm_step(data[3:0]);
                push_pcm(1'b0);
                if (byte_pos == {1'b0, loop_byte})
                begin
                    saved_pred = voice_pred;
                    saved_idx  = voice_idx;
                end
                adpcm_step(data[7:4]);
                push_pcm(1'b1);
                byte_pos = byte_pos + 19'd1;
            end
            imadec_pkg::KIND_RESTART:
            begin
                voice_pred = saved_pred;
                voice_idx  = saved_idx;
                push_pcm(1'b0);
                adpcm_step(data[7:4]);
                push_pcm(1'b1);
                byte_pos = {1'b0, loop_byte} + 19'd1;
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pcm_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected sample: got %0d last %0b", m_tdata, m_tlast);
            end
            else
            begin
                want_pcm = pcm_expected.pop_front();
                if (m_tdata !== want_pcm.sample || m_tlast !== want_pcm.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("sample mismatch: exp %0d last %0b, got %0d last %0b",
                                 want_pcm.sample, want_pcm.last, m_tdata, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [31:0] data);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        predict_pcm(kind, data);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pcm_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_loop_start(input logic [17:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        loop_byte = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_before_header();
        write_loop_start(18'd0);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0093);
        send_item(imadec_pkg::KIND_DATA, 32'hFFFF_FF5A);
        send_item(KIND_UNUSED, 32'h0000_00FF);
        send_item(imadec_pkg::KIND_RESTART, 32'hFFFF_FFC0);
        wait_drain();
    endtask

    task automatic test_sample_extremes();
        send_item(imadec_pkg::KIND_HEADER, 32'h0000_8000);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0080);
        send_item(imadec_pkg::KIND_HEADER, 32'h0058_7FFF);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0077);
        send_item(imadec_pkg::KIND_HEADER, 32'hFFFF_8001);
        send_item(imadec_pkg::KIND_DATA, 32'hABCD_EFFF);
        send_item(imadec_pkg::KIND_HEADER, 32'h0000_0000);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0010);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0032);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0054);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0076);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0098);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_00BA);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_00DC);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_00FE);
        wait_drain();
    endtask

    task automatic test_loop_points();
        write_loop_start(18'd4);
        send_item(imadec_pkg::KIND_HEADER, 32'h0030_1234);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_003C);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_00A5);
        send_item(imadec_pkg::KIND_RESTART, 32'h0000_0070);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_000F);
        send_item(imadec_pkg::KIND_RESTART, 32'h5500_00E1);
        wait_drain();
        write_loop_start(LOOP_MAX);
        send_item(imadec_pkg::KIND_HEADER, 32'h0010_F000);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0044);
        send_item(imadec_pkg::KIND_RESTART, 32'h0000_009B);
        send_item(imadec_pkg::KIND_DATA, 32'h0000_0021);
        wait_drain();
    endtask

    task automatic test_random_sound(input int n_items, input int idle_pct,
                                     input int stall_pct, input logic [17:0] start_byte);
        int sent;
        int pick;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        write_loop_start(start_byte);
        send_item(imadec_pkg::KIND_HEADER, $urandom());
        sent = 1;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            // hold off at the halfway point until every sample is out
            if (sent == n_items / 2)
            begin
                s_tvalid <= 1'b0;
                while (pcm_expected.size() != 0)
                    @(negedge clk);
            end
            if (pick < 4)
                send_item(imadec_pkg::KIND_HEADER, $urandom());
            else if (pick < 7)
                send_item(KIND_UNUSED, $urandom());
            else if (pick < 16)
                send_item(imadec_pkg::KIND_RESTART, $urandom());
            else
                send_item(imadec_pkg::KIND_DATA, $urandom());
            if (pick >= 4 && pick < 7)
                continue;
            sent++;
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = imadec_pkg::KIND_HEADER;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        voice_pred     = '0;
        voice_idx      = '0;
        saved_pred     = '0;
        saved_idx      = '0;
        byte_pos       = '0;
        loop_byte      = '0;
        mismatch_count = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_before_header();
        test_sample_extremes();
        test_loop_points();
        test_random_sound(200, 0, 0, 18'($urandom_range(4, 24)));
        test_random_sound(200, 64, 0, 18'($urandom_range(4, 24)));
        test_random_sound(200, 0, 64, 18'($urandom_range(4, 24)));
        test_random_sound(200, 38, 38, 18'($urandom_range(4, 24)));

        if (mismatch_count == 0 && pcm_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
